// File: rtl/bba_pkg.sv
// Shared types, codes and helpers for the buddy block allocator.
package bba_pkg;

	localparam int LEVELS = 7;
	localparam int NODE_W = LEVELS;
	localparam int DEP_W = 3;
	localparam int ADDR_W = 9;
	localparam int SIZE_W = 10;
	localparam int MIN_SHIFT = 3;
	localparam int NODES = 1 << LEVELS;

	typedef enum logic [1:0] {
		NODE_ABSENT = 2'd0,
		NODE_FREE   = 2'd1,
		NODE_USED   = 2'd2,
		NODE_SPLIT  = 2'd3
	} node_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_BAD_SIZE = 2'd1,
		STAT_NO_SPACE = 2'd2,
		STAT_BAD_ADDR = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_A_RD,
		S_A_CK,
		S_SPLIT,
		S_RIGHT,
		S_USE,
		S_F_RD,
		S_F_CK,
		S_M_RD,
		S_M_CK,
		S_M_CLR,
		S_M_UP
	} fsm_t;

	typedef enum logic [0:0] {
		FUNC_ALLOC = 1'b0,
		FUNC_FREE  = 1'b1
	} func_t;

	// Returns {valid, depth} for a requested byte size.
	function automatic logic [DEP_W:0] size_depth(input logic [SIZE_W-1:0] size);
		logic [DEP_W:0] r;
		r = '0;
		for (int d = 0; d < LEVELS; d++) begin
			if (size == SIZE_W'(1 << (MIN_SHIFT + LEVELS - 1 - d)))
				r = {1'b1, DEP_W'(d)};
		end
		return r;
	endfunction

endpackage

// File: rtl/buddy_block_allocator_top.sv
// Buddy block allocator: node tree held in one synchronous memory.
//
// Channel  | Signals                          | Handshake
// request  | func, req_size, block_addr       | start high while busy low
// result   | status, granted_addr             | done high for one cycle
//
// An item runs through a sequencer that reads one tree node at a time from
// the node memory; alloc scans up to 127 nodes and splits down to the
// target depth, free checks up to seven nodes and then merges free buddies
// upward. The result is registered once the item finishes. Reset clears
// the per-node valid bits at once, so no clearing pass is needed. The
// receiver cannot stall; busy holds off new items.
module buddy_block_allocator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          func,
	input  logic [bba_pkg::SIZE_W-1:0]    req_size,
	input  logic [bba_pkg::ADDR_W-1:0]    block_addr,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [bba_pkg::ADDR_W-1:0]    granted_addr
);
	import bba_pkg::*;

	fsm_t state_q, state_d;

	logic [1:0] mem [NODES];
	logic [NODES-1:0] vld_q;
	logic [1:0] rd_s1;
	logic [NODE_W-1:0] ra_s1;

	logic [NODE_W-1:0] idx_q;
	logic [DEP_W-1:0] dep_q, tgt_q;
	logic [ADDR_W-1:0] addr_q;
	logic done_q;
	status_t status_q;
	logic [ADDR_W-1:0] granted_q;

	logic re, we;
	logic [NODE_W-1:0] ra, wa;
	node_t wd;
	node_t rd_eff;
	logic [DEP_W:0] sz_dec;
	logic lvl_last, aligned;
	logic [NODE_W-1:0] cand;
	logic [NODE_W-1:0] off;
	logic [15:0] grant_w;

	assign sz_dec = size_depth(req_size);
	assign rd_eff = vld_q[ra_s1] ? node_t'(rd_s1)
		: ((ra_s1 == NODE_W'(1)) ? NODE_FREE : NODE_ABSENT);
	assign lvl_last = (idx_q == NODE_W'((8'd2 << dep_q) - 8'd1));
	assign aligned = ((10'(addr_q) & ((10'd1 << (4'd9 - 4'(dep_q))) - 10'd1)) == 10'd0);
	assign cand = NODE_W'((8'd1 << dep_q) + 8'(addr_q >> (4'd9 - 4'(dep_q))));
	assign off = idx_q - NODE_W'(8'd1 << dep_q);
	assign grant_w = 16'(off) << (4'd9 - 4'(dep_q));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (func == FUNC_FREE) state_d = S_F_RD;
					else if (sz_dec[DEP_W]) state_d = S_A_RD;
				end
			end
			S_A_RD: state_d = S_A_CK;
			S_A_CK: begin
				if (rd_eff == NODE_FREE)
					state_d = (dep_q == tgt_q) ? S_USE : S_SPLIT;
				else if (lvl_last && dep_q == '0)
					state_d = S_IDLE;
				else
					state_d = S_A_RD;
			end
			S_SPLIT: state_d = S_RIGHT;
			S_RIGHT: state_d = (dep_q + 1'b1 == tgt_q) ? S_USE : S_SPLIT;
			S_USE: state_d = S_IDLE;
			S_F_RD: begin
				if (aligned) state_d = S_F_CK;
				else if (dep_q == '0) state_d = S_IDLE;
			end
			S_F_CK: begin
				if (rd_eff == NODE_FREE || rd_eff == NODE_USED) state_d = S_M_RD;
				else if (dep_q == '0) state_d = S_IDLE;
				else state_d = S_F_RD;
			end
			S_M_RD: state_d = (idx_q == NODE_W'(1)) ? S_IDLE : S_M_CK;
			S_M_CK: state_d = (rd_eff == NODE_FREE) ? S_M_CLR : S_IDLE;
			S_M_CLR: state_d = S_M_UP;
			S_M_UP: state_d = S_M_RD;
			default: state_d = S_IDLE;
		endcase
	end

	// Memory controls.
	always_comb begin
		re = 1'b0;
		ra = idx_q;
		we = 1'b0;
		wa = idx_q;
		wd = NODE_ABSENT;
		unique case (state_q)
			S_A_RD: re = 1'b1;
			S_F_RD: begin
				re = aligned;
				ra = cand;
			end
			S_SPLIT: begin
				we = 1'b1;
				wd = NODE_SPLIT;
			end
			S_RIGHT: begin
				we = 1'b1;
				wa = {idx_q[NODE_W-2:0], 1'b1};
				wd = NODE_FREE;
			end
			S_USE: begin
				we = 1'b1;
				wd = NODE_USED;
			end
			S_F_CK: begin
				we = (rd_eff == NODE_FREE || rd_eff == NODE_USED);
				wd = NODE_FREE;
			end
			S_M_RD: begin
				re = (idx_q != NODE_W'(1));
				ra = idx_q ^ NODE_W'(1);
			end
			S_M_CK: begin
				we = (rd_eff == NODE_FREE);
				wd = NODE_ABSENT;
			end
			S_M_CLR: begin
				we = 1'b1;
				wa = idx_q ^ NODE_W'(1);
				wd = NODE_ABSENT;
			end
			S_M_UP: begin
				we = 1'b1;
				wa = idx_q >> 1;
				wd = NODE_FREE;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (re) begin
			rd_s1 <= mem[ra];
			ra_s1 <= ra;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[wa] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
			status_q <= STAT_OK;
			granted_q <= '0;
			idx_q <= '0;
			dep_q <= '0;
			tgt_q <= '0;
			addr_q <= '0;
		end else begin
			state_q <= state_d;
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						addr_q <= block_addr;
						if (func == FUNC_FREE) begin
							dep_q <= DEP_W'(LEVELS - 1);
						end else if (sz_dec[DEP_W]) begin
							tgt_q <= sz_dec[DEP_W-1:0];
							dep_q <= sz_dec[DEP_W-1:0];
							idx_q <= NODE_W'(8'd1 << sz_dec[DEP_W-1:0]);
						end else begin
							done_q <= 1'b1;
							status_q <= STAT_BAD_SIZE;
							granted_q <= '0;
						end
					end
				end
				S_A_CK: begin
					if (rd_eff != NODE_FREE) begin
						if (lvl_last) begin
							if (dep_q == '0) begin
								done_q <= 1'b1;
								status_q <= STAT_NO_SPACE;
								granted_q <= '0;
							end else begin
								dep_q <= dep_q - 1'b1;
								idx_q <= NODE_W'(8'd1 << (dep_q - 1'b1));
							end
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_RIGHT: begin
					idx_q <= {idx_q[NODE_W-2:0], 1'b0};
					dep_q <= dep_q + 1'b1;
				end
				S_USE: begin
					done_q <= 1'b1;
					status_q <= STAT_OK;
					granted_q <= grant_w[ADDR_W-1:0];
				end
				S_F_RD: begin
					if (aligned) begin
						idx_q <= cand;
					end else if (dep_q == '0) begin
						done_q <= 1'b1;
						status_q <= STAT_BAD_ADDR;
						granted_q <= '0;
					end else begin
						dep_q <= dep_q - 1'b1;
					end
				end
				S_F_CK: begin
					if (!(rd_eff == NODE_FREE || rd_eff == NODE_USED)) begin
						if (dep_q == '0) begin
							done_q <= 1'b1;
							status_q <= STAT_BAD_ADDR;
							granted_q <= '0;
						end else begin
							dep_q <= dep_q - 1'b1;
						end
					end
				end
				S_M_RD: begin
					if (idx_q == NODE_W'(1)) begin
						done_q <= 1'b1;
						status_q <= STAT_OK;
						granted_q <= '0;
					end
				end
				S_M_CK: begin
					if (rd_eff != NODE_FREE) begin
						done_q <= 1'b1;
						status_q <= STAT_OK;
						granted_q <= '0;
					end
				end
				S_M_UP: idx_q <= idx_q >> 1;
				default: begin
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign status = status_q;
	assign granted_addr = granted_q;

	a_done_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("result without an item");
	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != STAT_OK) |-> granted_addr == '0)
		else $error("nonzero address on error");
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(we && re))
		else $error("read and write in one cycle");
	a_item_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == FUNC_FREE) |=> busy)
		else $error("free item not taken up");

endmodule

// File: tb/tb.sv
// Self-checking testbench for the buddy block allocator top level.
`timescale 1ns / 100ps

module tb;
	import bba_pkg::*;

	localparam int DEPTHS = 7;
	localparam int CYCLE_LIMIT = 1500000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic func;
	logic [SIZE_W-1:0] req_size;
	logic [ADDR_W-1:0] block_addr;
	logic done;
	logic [1:0] status;
	logic [ADDR_W-1:0] granted_addr;

	typedef struct packed {
		logic [1:0] st;
		logic [ADDR_W-1:0] addr;
	} grant_t;

	node_t tree[NODES];
	grant_t pending_grants[$];
	logic [ADDR_W-1:0] held_blocks[$];
	int mismatches;
	int cycles;
	bit quiet_sender;

	buddy_block_allocator_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.req_size(req_size),
		.block_addr(block_addr),
		.done(done),
		.status(status),
		.granted_addr(granted_addr)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int bytes_at(int depth);
		return 8 << (DEPTHS - 1 - depth);
	endfunction

	function automatic void tree_reset();
		foreach (tree[i]) tree[i] = NODE_ABSENT;
		tree[1] = NODE_FREE;
	endfunction

	// Computes the allocator's answer and updates the shadow tree.
	function automatic grant_t allocate_or_free(logic f, logic [SIZE_W-1:0] sz,
			logic [ADDR_W-1:0] ad);
		grant_t r;
		int target;
		int node;
		int lvl;
		r.st = STAT_OK;
		r.addr = '0;
		target = -1;
		node = 0;
		if (f == FUNC_ALLOC) begin
			for (int d = 0; d < DEPTHS; d++)
				if (target < 0 && bytes_at(d) == sz) target = d;
			if (target < 0) begin
				r.st = STAT_BAD_SIZE;
			end else begin
				lvl = target;
				while (lvl >= 0 && node == 0) begin
					for (int i = 1 << lvl; i < (2 << lvl); i++)
						if (node == 0 && tree[i] == NODE_FREE) node = i;
					if (node == 0) lvl--;
				end
				if (node == 0) begin
					r.st = STAT_NO_SPACE;
				end else begin
					while (lvl < target) begin
						tree[node] = NODE_SPLIT;
						tree[2 * node + 1] = NODE_FREE;
						node = 2 * node;
						lvl++;
					end
					tree[node] = NODE_USED;
					r.addr = ADDR_W'((node - (1 << lvl)) * bytes_at(lvl));
				end
			end
		end else begin
			for (int d = DEPTHS - 1; d >= 0; d--) begin
				if (node == 0 && ad % bytes_at(d) == 0 && ad / bytes_at(d) < (1 << d))
					if (tree[(1 << d) + ad / bytes_at(d)] inside {NODE_FREE, NODE_USED})
						node = (1 << d) + ad / bytes_at(d);
			end
			if (node == 0) begin
				r.st = STAT_BAD_ADDR;
			end else begin
				tree[node] = NODE_FREE;
				while (node > 1 && tree[node ^ 1] == NODE_FREE) begin
					tree[node] = NODE_ABSENT;
					tree[node ^ 1] = NODE_ABSENT;
					node = node >> 1;
					tree[node] = NODE_FREE;
				end
			end
		end
		return r;
	endfunction

	// Called at a falling edge; start stays high after the item is taken so
	// that a following item can be driven at once.
	task automatic send_request(logic f, logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] ad);
		grant_t g;
		if (!quiet_sender)
			while ($urandom_range(99) < 8) begin
				start <= 1'b0;
				@(negedge clk);
			end
		while (busy) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		func <= f;
		req_size <= sz;
		block_addr <= ad;
		g = allocate_or_free(f, sz, ad);
		pending_grants.push_back(g);
		if (f == FUNC_ALLOC && g.st == STAT_OK) held_blocks.push_back(g.addr);
		@(negedge clk);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (pending_grants.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Every block size, bad sizes, exhaustion, and frees of odd addresses.
	task automatic test_directed();
		for (int d = DEPTHS - 1; d >= 0; d--) send_request(FUNC_ALLOC, SIZE_W'(bytes_at(d)), '0);
		send_request(FUNC_ALLOC, 10'd512, '0);
		send_request(FUNC_ALLOC, 10'd0, 9'h1ff);
		send_request(FUNC_ALLOC, 10'd1023, '0);
		send_request(FUNC_ALLOC, 10'd24, '0);
		send_request(FUNC_FREE, 10'h3ff, 9'd4);
		send_request(FUNC_FREE, '0, 9'd511);
		send_request(FUNC_FREE, '0, 9'd0);
		send_request(FUNC_FREE, '0, 9'd0);
		send_request(FUNC_FREE, '0, 9'd8);
		send_request(FUNC_FREE, '0, 9'd256);
		send_request(FUNC_FREE, '0, 9'd128);
		send_request(FUNC_FREE, '0, 9'd64);
		send_request(FUNC_FREE, '0, 9'd32);
		send_request(FUNC_FREE, '0, 9'd16);
		send_request(FUNC_FREE, '0, 9'd0);
		held_blocks.delete();
	endtask

	// Mostly allocations of valid sizes and frees of live blocks, with a share of noise.
	task automatic test_random(int count);
		int k;
		int pick;
		for (int n = 0; n < count; n++) begin
			quiet_sender = (n >= count / 3 && n < count / 2);
			pick = $urandom_range(99);
			if (pick < 45) begin
				send_request(FUNC_ALLOC, SIZE_W'(bytes_at($urandom_range(6, 2))),
					ADDR_W'($urandom));
			end else if (pick < 52) begin
				send_request(FUNC_ALLOC, SIZE_W'(bytes_at($urandom_range(6))),
					ADDR_W'($urandom));
			end else if (pick < 88 && held_blocks.size() != 0) begin
				k = $urandom_range(held_blocks.size() - 1);
				send_request(FUNC_FREE, SIZE_W'($urandom), held_blocks[k]);
				held_blocks.delete(k);
			end else if (pick < 94) begin
				send_request(FUNC_ALLOC, SIZE_W'($urandom), ADDR_W'($urandom));
			end else begin
				send_request(FUNC_FREE, SIZE_W'($urandom), ADDR_W'($urandom));
			end
			if (n == count / 2) drain_results();
		end
		quiet_sender = 1'b0;
	endtask

	// Compares each strobed result with the oldest expectation.
	always @(posedge clk) begin
		grant_t want;
		if (arst_n && done) begin
			if (pending_grants.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result status=%0d addr=%0d", status, granted_addr);
			end else begin
				want = pending_grants.pop_front();
				if (status !== want.st || granted_addr !== want.addr) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: status exp %0d got %0d, addr exp %0d got %0d",
							want.st, status, want.addr, granted_addr);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		mismatches = 0;
		cycles = 0;
		quiet_sender = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		func = 1'b0;
		req_size = '0;
		block_addr = '0;
		tree_reset();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(1200);
		drain_results();
		if (mismatches == 0 && pending_grants.size() == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
